// ===== rtl/core/fpds_pkg.sv =====
// Shared definitions for the five-point diffusion stencil.
// Holds the default sizes, configuration register layout and fixed constants.
// Depends on nothing; every other file of the block uses it.
package fpds_pkg;

	localparam int MAX_WIDTH_DEF   = 8192;
	localparam int SAMPLE_BITS_DEF = 16;

	localparam int CFG_INDEX_BITS  = 2;
	localparam int CFG_DATA_BITS   = 16;
	localparam int WIDTH_REG_BITS  = 14;
	localparam int HEIGHT_REG_BITS = 16;

	localparam logic [WIDTH_REG_BITS-1:0]  WIDTH_RESET  = 14'd8192;
	localparam logic [HEIGHT_REG_BITS-1:0] HEIGHT_RESET = 16'd8192;

	// Smallest grid edge that the stencil handles.
	localparam int GRID_MIN = 3;
	// Number of points that are averaged.
	localparam int DIVISOR  = 5;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_GRID_WIDTH  = 2'd0,
		REG_GRID_HEIGHT = 2'd1
	} cfg_reg_t;

endpackage

// ===== rtl/core/fpds_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// Used for the line buffers of the stencil; takes only its default size from fpds_pkg.
module fpds_ram #(
	parameter int WIDTH = fpds_pkg::SAMPLE_BITS_DEF,
	parameter int DEPTH = fpds_pkg::MAX_WIDTH_DEF,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/core/five_point_diffusion_stencil.sv =====
// Top level of the five-point diffusion stencil: one Jacobi step over a raster stream.
// Depends on fpds_pkg and on fpds_ram for the two line buffers.
//
// Usage. Grid samples enter in raster order on the in_valid/in_ready channel and
// new point values leave on out_valid/out_ready; each channel moves one item per
// transfer. The grid size is set through the write port (cfg_we, cfg_index,
// cfg_data); the user must write it only while the block is idle, typically
// between frames; the block does not enforce this. A sample of row r releases
// the point of row r-1 in the same column; samples of the last row are also passed
// on themselves, the final one with frame_last set. The first row releases nothing.
// Interior points become the floor of the five-point sum divided by five; border
// points pass through unchanged. One sample is taken per cycle while the output
// keeps up; in the last row each sample yields two results, so the output port
// sets the pace there. Each line buffer is read once and written once per sample,
// which sets the rate. When the receiver stalls, the four-stage pipeline fills and
// in_ready falls only once no stage can move. Reset clears the counters, window
// and pipeline, and restores the default grid of 8192 by 8192; the line buffers
// are not cleared.
module five_point_diffusion_stencil #(
	parameter int MAX_WIDTH   = fpds_pkg::MAX_WIDTH_DEF,
	parameter int SAMPLE_BITS = fpds_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [fpds_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [fpds_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [SAMPLE_BITS-1:0]              sample_in,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [SAMPLE_BITS-1:0]              sample_out,
	output logic                                frame_last
);

	import fpds_pkg::*;

	localparam int CW   = $clog2(MAX_WIDTH);
	localparam int EW   = (WIDTH_REG_BITS > CW + 1) ? WIDTH_REG_BITS : CW + 1;
	localparam int HB   = HEIGHT_REG_BITS;
	localparam int SUMW = SAMPLE_BITS + 3;
	localparam logic [SUMW-1:0] RECIP = SUMW'((64'd1 << SUMW) / 64'(DIVISOR));
	localparam logic [EW-1:0]   MAX_W = EW'(MAX_WIDTH);
	localparam logic [EW-1:0]   MIN_W = EW'(GRID_MIN);
	localparam logic [HB-1:0]   MIN_H = HB'(GRID_MIN);

	// Configuration registers.
	logic [WIDTH_REG_BITS-1:0] grid_width_q;
	logic [HB-1:0]             grid_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= WIDTH_RESET;
			grid_height_q <= HEIGHT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_GRID_WIDTH:  grid_width_q  <= cfg_data[WIDTH_REG_BITS-1:0];
				REG_GRID_HEIGHT: grid_height_q <= cfg_data[HB-1:0];
				default: ;
			endcase
		end
	end

	logic [EW-1:0] gw_ext;
	logic [EW-1:0] w_eff;
	logic [HB-1:0] h_eff;

	assign gw_ext = EW'(grid_width_q);
	assign w_eff  = (gw_ext < MIN_W) ? MIN_W : ((gw_ext > MAX_W) ? MAX_W : gw_ext);
	assign h_eff  = (grid_height_q < MIN_H) ? MIN_H : grid_height_q;

	// Raster position and pipeline control.
	logic [CW-1:0] col_q;
	logic [HB-1:0] row_q;
	logic [EW-1:0] col_inc;
	logic          col_wrap;
	logic [CW-1:0] col_next;
	logic [HB:0]   row_inc;
	logic          last_row;
	logic [HB-1:0] row_next;
	logic          inner;
	logic          accept;

	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic en1, en2, en3, go1, go2, go3, take4, res_s3, final_s4, out_xfer;

	assign col_inc  = EW'(col_q) + EW'(1);
	assign col_wrap = col_inc >= w_eff;
	assign col_next = col_wrap ? '0 : col_inc[CW-1:0];
	assign row_inc  = {1'b0, row_q} + (HB+1)'(1);
	assign last_row = row_inc >= {1'b0, h_eff};
	assign row_next = last_row ? '0 : row_inc[HB-1:0];
	assign inner    = (row_q >= HB'(2)) && (row_q < h_eff) && (col_q != '0) && !col_wrap;

	assign out_xfer = out_valid && out_ready;
	assign take4    = !valid_s4 || (out_ready && final_s4);
	assign go3      = valid_s3 && (!res_s3 || take4);
	assign en3      = !valid_s3 || go3;
	assign go2      = valid_s2 && en3;
	assign en2      = !valid_s2 || en3;
	assign go1      = valid_s1 && en2;
	assign en1      = !valid_s1 || en2;
	assign in_ready = en1;
	assign accept   = in_valid && en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			col_q <= col_next;
			if (col_wrap) begin
				row_q <= row_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (en1) begin
				valid_s1 <= in_valid;
			end
			if (en2) begin
				valid_s2 <= valid_s1;
			end
			if (en3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	// Stage 1: line buffer reads land here.
	logic [SAMPLE_BITS-1:0] sample_s1;
	logic [CW-1:0]          col_s1;
	logic                   has_a_s1, inner_s1, last_row_s1, flast_s1;

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1   <= sample_in;
			col_s1      <= col_q;
			has_a_s1    <= row_q != '0;
			inner_s1    <= inner;
			last_row_s1 <= last_row;
			flast_s1    <= col_wrap;
		end
	end

	// The read of line_above fetches the next column: it is the right neighbour of the
	// point that this sample releases and the next sample's centre.
	logic [SAMPLE_BITS-1:0] above_rd, two_rd;
	logic [SAMPLE_BITS-1:0] centre_q, left_q;

	fpds_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_WIDTH)) u_line_above (
		.clk   (clk),
		.we    (go1),
		.waddr (col_s1),
		.wdata (sample_s1),
		.re    (accept),
		.raddr (col_next),
		.rdata (above_rd)
	);

	fpds_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_WIDTH)) u_line_two_above (
		.clk   (clk),
		.we    (go1),
		.waddr (col_s1),
		.wdata (centre_q),
		.re    (accept),
		.raddr (col_q),
		.rdata (two_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			centre_q <= '0;
			left_q   <= '0;
		end else if (go1) begin
			centre_q <= above_rd;
			left_q   <= centre_q;
		end
	end

	logic [SUMW-1:0] sum_s1;

	assign sum_s1 = SUMW'(centre_q) + SUMW'(left_q) + SUMW'(above_rd)
	              + SUMW'(two_rd) + SUMW'(sample_s1);

	// Stage 2: five-point sum.
	logic [SUMW-1:0]        sum_s2;
	logic [SAMPLE_BITS-1:0] centre_s2, sample_s2;
	logic                   has_a_s2, inner_s2, last_row_s2, flast_s2;

	always_ff @(posedge clk) begin
		if (go1) begin
			sum_s2      <= sum_s1;
			centre_s2   <= centre_q;
			sample_s2   <= sample_s1;
			has_a_s2    <= has_a_s1;
			inner_s2    <= inner_s1;
			last_row_s2 <= last_row_s1;
			flast_s2    <= flast_s1;
		end
	end

	logic [2*SUMW-1:0] prod_s2;

	assign prod_s2 = (2*SUMW)'(sum_s2) * (2*SUMW)'(RECIP);

	// Stage 3: reciprocal estimate of the quotient, at most one too small.
	logic [SUMW-1:0]        est_s3, sum_s3;
	logic [SAMPLE_BITS-1:0] centre_s3, sample_s3;
	logic                   has_a_s3, inner_s3, last_row_s3, flast_s3;

	always_ff @(posedge clk) begin
		if (go2) begin
			est_s3      <= prod_s2[2*SUMW-1:SUMW];
			sum_s3      <= sum_s2;
			centre_s3   <= centre_s2;
			sample_s3   <= sample_s2;
			has_a_s3    <= has_a_s2;
			inner_s3    <= inner_s2;
			last_row_s3 <= last_row_s2;
			flast_s3    <= flast_s2;
		end
	end

	logic [SUMW-1:0]        five_est, rem_s3, quot_s3;
	logic [SAMPLE_BITS-1:0] val_a_s3;

	assign five_est = (est_s3 << 2) + est_s3;
	assign rem_s3   = sum_s3 - five_est;
	assign quot_s3  = est_s3 + SUMW'(rem_s3 >= SUMW'(DIVISOR));
	assign val_a_s3 = inner_s3 ? quot_s3[SAMPLE_BITS-1:0] : centre_s3;
	assign res_s3   = has_a_s3 || last_row_s3;

	// Stage 4: output register holding up to two results.
	logic [SAMPLE_BITS-1:0] val_a_s4, val_b_s4;
	logic                   has_a_s4, has_b_s4, flast_s4, second_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			second_q <= 1'b0;
		end else if (take4) begin
			valid_s4 <= go3 && res_s3;
			second_q <= 1'b0;
		end else if (out_xfer) begin
			second_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (go3 && res_s3 && take4) begin
			val_a_s4 <= val_a_s3;
			val_b_s4 <= sample_s3;
			has_a_s4 <= has_a_s3;
			has_b_s4 <= last_row_s3;
			flast_s4 <= flast_s3;
		end
	end

	logic show_a;

	assign final_s4   = !(has_a_s4 && has_b_s4) || second_q;
	assign show_a     = has_a_s4 && !second_q;
	assign out_valid  = valid_s4;
	assign sample_out = show_a ? val_a_s4 : val_b_s4;
	assign frame_last = !show_a && flast_s4;

endmodule

// ===== rtl/core/fpds_checker.sv =====
// Port-level checks for the five-point diffusion stencil, bound to the top level.
// Depends on fpds_pkg for the default sample width.
module fpds_checker #(
	parameter int SAMPLE_BITS = fpds_pkg::SAMPLE_BITS_DEF
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_ready,
	input logic                   out_valid,
	input logic                   out_ready,
	input logic [SAMPLE_BITS-1:0] sample_out,
	input logic                   frame_last
);

	// A pending result stays offered until its transfer.
	a_out_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("out_valid dropped before its transfer");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(sample_out) && $stable(frame_last))
		else $error("output payload changed while stalled");

	// Without a waiting result nothing can hold the pipeline back.
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled although the output is empty");

	// The last point of a frame is never followed at once by another.
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && frame_last |=> !(out_valid && frame_last))
		else $error("two end-of-frame results in a row");

endmodule

bind five_point_diffusion_stencil fpds_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_fpds_checker (.*);

// ===== dv/tb_five_point_diffusion_stencil.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for five_point_diffusion_stencil: raster frames in, stepped points out.
// Depends on fpds_pkg and the block's RTL; a scoreboard class predicts every point from the samples.
module tb_five_point_diffusion_stencil;
	import fpds_pkg::*;

	localparam int GRID_COLS_MAX = MAX_WIDTH_DEF;
	localparam int SBITS = SAMPLE_BITS_DEF;
	localparam int PIPE_SETTLE = 16;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int RANDOM_SAMPLES = 1500;
	localparam longint CYCLE_LIMIT = 2000000;
	localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_LO = 2'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_HI = 2'd3;

	typedef enum {FILL_ONES, FILL_CHECKER, FILL_RANDOM} fill_t;

	typedef struct packed {
		logic [SBITS-1:0] value;
		logic             last;
	} point_t;

	class diffusion_scoreboard;
		bit [WIDTH_REG_BITS-1:0]  width_reg;
		bit [HEIGHT_REG_BITS-1:0] height_reg;
		bit [SBITS-1:0]           row_two_up [GRID_COLS_MAX];
		bit [SBITS-1:0]           row_one_up [GRID_COLS_MAX];
		bit [SBITS-1:0]           left_of_centre;
		bit [SBITS-1:0]           centre;
		int unsigned              column;
		int unsigned              row;
		point_t                   pending_points[$];
		int unsigned              errors;
		int unsigned              results;

		function new();
			width_reg = WIDTH_RESET;
			height_reg = HEIGHT_RESET;
		endfunction

		function void write_reg(logic [CFG_INDEX_BITS-1:0] index, logic [CFG_DATA_BITS-1:0] data);
			case (index)
				REG_GRID_WIDTH: width_reg = data[WIDTH_REG_BITS-1:0];
				REG_GRID_HEIGHT: height_reg = data[HEIGHT_REG_BITS-1:0];
				default: ;
			endcase
		endfunction

		function int unsigned cols();
			int unsigned w;
			w = width_reg;
			if (w < GRID_MIN) w = GRID_MIN;
			if (w > GRID_COLS_MAX) w = GRID_COLS_MAX;
			return w;
		endfunction

		function int unsigned rows();
			int unsigned h;
			h = height_reg;
			if (h < GRID_MIN) h = GRID_MIN;
			return h;
		endfunction

		function void take_sample(logic [SBITS-1:0] s);
			int unsigned w, h, c, r, right, sum;
			bit bottom;
			point_t pt;
			w = cols();
			h = rows();
			c = column;
			r = row;
			bottom = (r + 1 >= h);
			if (c >= GRID_COLS_MAX) c = 0;
			right = (c + 1 < GRID_COLS_MAX) ? row_one_up[c + 1] : 0;
			left_of_centre = centre;
			centre = row_one_up[c];
			if (r >= 1) begin
				pt.value = centre;
				pt.last = 1'b0;
				if (r >= 2 && r < h && c >= 1 && c + 1 < w) begin
					sum = int'(centre) + int'(left_of_centre) + right + int'(row_two_up[c]) + int'(s);
					pt.value = SBITS'(sum / DIVISOR);
				end
				pending_points.push_back(pt);
			end
			if (bottom) begin
				pt.value = s;
				pt.last = (c + 1 >= w);
				pending_points.push_back(pt);
			end
			row_two_up[c] = row_one_up[c];
			row_one_up[c] = s;
			if (c + 1 >= w) begin
				column = 0;
				row = bottom ? 0 : ((r + 1) & 16'hFFFF);
			end else begin
				column = c + 1;
			end
		endfunction

		function void match_point(logic [SBITS-1:0] value, logic last);
			point_t want;
			results++;
			if (pending_points.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, sample_out %h frame_last %b", $time, value, last);
				return;
			end
			want = pending_points.pop_front();
			if (value !== want.value) begin
				errors++;
				$display("%0t: sample_out mismatch, expected %h, got %h", $time, want.value, value);
			end
			if (last !== want.last) begin
				errors++;
				$display("%0t: frame_last mismatch, expected %b, got %b", $time, want.last, last);
			end
		endfunction
	endclass

	bit                         clk = 1'b0;
	logic                       arst_n;
	logic                       cfg_we;
	logic [CFG_INDEX_BITS-1:0]  cfg_index;
	logic [CFG_DATA_BITS-1:0]   cfg_data;
	logic                       in_valid;
	logic                       in_ready;
	logic [SBITS-1:0]           sample_in;
	logic                       out_valid;
	logic                       out_ready;
	logic [SBITS-1:0]           sample_out;
	logic                       frame_last;

	diffusion_scoreboard board;
	bit          idling;
	bit          squeeze;
	longint      cycles;
	int unsigned samples_sent;
	int unsigned frames_run;
	int unsigned settings_used;

	five_point_diffusion_stencil DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.sample_in  (sample_in),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.sample_out (sample_out),
		.frame_last (frame_last)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles.", cycles);
			$display("Some tests failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) board.match_point(sample_out, frame_last);
	end

	// The receiver takes one long break on request so that the pipeline fills and stalls its input.
	initial begin
		int gap;
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			gap = idling ? $urandom_range(0, 9) : 0;
			if (squeeze) begin
				gap = HOLD_OFF_CYCLES;
				squeeze = 1'b0;
			end
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	function automatic logic [SBITS-1:0] pick_sample();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2: return SBITS'(16'hFFFF - $urandom_range(0, 15));
			default: return SBITS'($urandom);
		endcase
	endfunction

	task automatic send_sample(logic [SBITS-1:0] s);
		int gap;
		gap = idling ? $urandom_range(0, 9) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		sample_in <= s;
		do @(posedge clk); while (!in_ready);
		board.take_sample(s);
		samples_sent++;
	endtask

	task automatic run_frame(fill_t fill);
		int unsigned w, n;
		logic [SBITS-1:0] s;
		w = board.cols();
		n = w * board.rows();
		for (int unsigned i = 0; i < n; i++) begin
			case (fill)
				FILL_ONES: s = '1;
				FILL_CHECKER: s = (((i / w) + (i % w)) & 1) ? '1 : '0;
				default: s = pick_sample();
			endcase
			send_sample(s);
		end
		frames_run++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (board.pending_points.size() != 0);
		repeat (PIPE_SETTLE) @(posedge clk);
	endtask

	task automatic program_grid(logic [CFG_DATA_BITS-1:0] width_data,
	                            logic [CFG_DATA_BITS-1:0] height_data);
		logic [CFG_INDEX_BITS-1:0] spare;
		logic [CFG_DATA_BITS-1:0]  junk;
		spare = $urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO;
		junk = CFG_DATA_BITS'($urandom);
		cfg_we <= 1'b1;
		cfg_index <= REG_GRID_WIDTH;
		cfg_data <= width_data;
		@(posedge clk);
		board.write_reg(REG_GRID_WIDTH, width_data);
		cfg_index <= spare;
		cfg_data <= junk;
		@(posedge clk);
		board.write_reg(spare, junk);
		cfg_index <= REG_GRID_HEIGHT;
		cfg_data <= height_data;
		@(posedge clk);
		board.write_reg(REG_GRID_HEIGHT, height_data);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	initial begin
		int unsigned random_count, start, frame_no;
		logic [CFG_DATA_BITS-1:0] wd, ht;
		board = new();
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_GRID_WIDTH;
		cfg_data <= '0;
		in_valid <= 1'b0;
		sample_in <= '0;
		idling = 1'b1;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		program_grid(16'd3, 16'd3);
		run_frame(FILL_ONES);
		drain();
		program_grid(16'd4, 16'd4);
		run_frame(FILL_CHECKER);

		random_count = 0;
		frame_no = 0;
		while (random_count < RANDOM_SAMPLES) begin
			if (frame_no == 0 || $urandom_range(0, 2) != 0) begin
				drain();
				wd = ($urandom_range(0, 5) == 0) ? CFG_DATA_BITS'($urandom_range(0, 2))
				                                 : CFG_DATA_BITS'($urandom_range(3, 12));
				wd[CFG_DATA_BITS-1:WIDTH_REG_BITS] =
					(CFG_DATA_BITS-WIDTH_REG_BITS)'($urandom_range(0, 3));
				ht = ($urandom_range(0, 5) == 0) ? CFG_DATA_BITS'($urandom_range(0, 2))
				                                 : CFG_DATA_BITS'($urandom_range(3, 10));
				program_grid(wd, ht);
			end
			idling = ($urandom_range(0, 3) != 0);
			if (frame_no == 4) begin
				idling = 1'b0;
				squeeze = 1'b1;
			end
			start = samples_sent;
			run_frame(FILL_RANDOM);
			random_count += samples_sent - start;
			frame_no++;
		end

		drain();

		$display("Streamed %0d samples in %0d frames over %0d grid settings; %0d points checked.",
			samples_sent, frames_run, settings_used, board.results);
		$display("Small grids, undersized and junk-padded settings, stalls on both sides.");
		if (board.errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end
endmodule

// ===== five_point_diffusion_stencil.f =====
rtl/core/fpds_pkg.sv
rtl/core/fpds_ram.sv
rtl/core/five_point_diffusion_stencil.sv
rtl/core/fpds_checker.sv
dv/tb_five_point_diffusion_stencil.sv
